// ----- rtl/core/smoothstep_fade_sequencer_core_macros.svh -----
// Assertion macros shared by the fade sequencer RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef SMOOTHSTEP_FADE_SEQUENCER_CORE_MACROS_SVH
`define SMOOTHSTEP_FADE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sfs_pkg.sv -----
// Shared constants, control word types and the microcode table of the fade sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sfs_pkg;

	// Time base and field widths.
	localparam int TIME_BITS = 16;
	localparam int LEN_W     = 16;
	localparam int ACT_W     = 2;
	localparam int PHASE_W   = 2;
	localparam int OPAC_W    = 16;
	localparam int CMP_W     = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;
	localparam int SUM_W     = CMP_W + 1;

	// Divider and multiplier widths.
	localparam int DIV_STEPS = LEN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int W_W       = 18;
	localparam int PP_W      = LEN_W + W_W;
	localparam int PROD_W    = PP_W + LEN_W + 1;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PH_OUT  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_IN   = 2'd2;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;

	// Datapath operations.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 4'd1;
	localparam logic [OP_W-1:0] OP_PREP   = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
	localparam logic [OP_W-1:0] OP_CVAL   = 4'd4;
	localparam logic [OP_W-1:0] OP_SQR    = 4'd5;
	localparam logic [OP_W-1:0] OP_MULH   = 4'd6;
	localparam logic [OP_W-1:0] OP_MULL   = 4'd7;
	localparam logic [OP_W-1:0] OP_FIN    = 4'd8;
	localparam logic [OP_W-1:0] OP_OUT    = 4'd9;

	// Branch conditions: when true the step counter loads the target, else it advances.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
	localparam logic [COND_W-1:0] COND_NO_INPUT = 3'd2;
	localparam logic [COND_W-1:0] COND_SKIP_DIV = 3'd3;
	localparam logic [COND_W-1:0] COND_DIV_MORE = 3'd4;
	localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd5;

	// Program addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
	localparam logic [PC_W-1:0] PC_PREP  = 4'd1;
	localparam logic [PC_W-1:0] PC_DIV   = 4'd2;
	localparam logic [PC_W-1:0] PC_CVAL  = 4'd3;
	localparam logic [PC_W-1:0] PC_SQR   = 4'd4;
	localparam logic [PC_W-1:0] PC_MULH  = 4'd5;
	localparam logic [PC_W-1:0] PC_MULL  = 4'd6;
	localparam logic [PC_W-1:0] PC_FIN   = 4'd7;
	localparam logic [PC_W-1:0] PC_OUT   = 4'd8;
	localparam logic [PC_W-1:0] PC_BACK  = 4'd9;

	typedef struct packed {
		logic                take_in;
		logic [OP_W-1:0]     op;
		logic [COND_W-1:0]   cond;
		logic [PC_W-1:0]     target;
	} sfs_cw_t;

	typedef struct packed {
		logic in_valid;
		logic skip_div;
		logic div_more;
		logic out_busy;
	} sfs_flags_t;

	function automatic sfs_cw_t sfs_cw(input logic take_in, input logic [OP_W-1:0] op,
		input logic [COND_W-1:0] cond, input logic [PC_W-1:0] target);
		sfs_cw_t w;
		w.take_in = take_in;
		w.op      = op;
		w.cond    = cond;
		w.target  = target;
		return w;
	endfunction

	// The microprogram.
	function automatic sfs_cw_t ucode(input logic [PC_W-1:0] pc);
		sfs_cw_t w;
		case (pc)
			PC_FETCH: w = sfs_cw(1'b1, OP_UPDATE, COND_NO_INPUT, PC_FETCH);
			PC_PREP:  w = sfs_cw(1'b0, OP_PREP,   COND_SKIP_DIV, PC_CVAL);
			PC_DIV:   w = sfs_cw(1'b0, OP_DIV,    COND_DIV_MORE, PC_DIV);
			PC_CVAL:  w = sfs_cw(1'b0, OP_CVAL,   COND_NEVER,    PC_FETCH);
			PC_SQR:   w = sfs_cw(1'b0, OP_SQR,    COND_NEVER,    PC_FETCH);
			PC_MULH:  w = sfs_cw(1'b0, OP_MULH,   COND_NEVER,    PC_FETCH);
			PC_MULL:  w = sfs_cw(1'b0, OP_MULL,   COND_NEVER,    PC_FETCH);
			PC_FIN:   w = sfs_cw(1'b0, OP_FIN,    COND_NEVER,    PC_FETCH);
			PC_OUT:   w = sfs_cw(1'b0, OP_OUT,    COND_OUT_BUSY, PC_OUT);
			PC_BACK:  w = sfs_cw(1'b0, OP_NOP,    COND_ALWAYS,   PC_FETCH);
			default:  w = sfs_cw(1'b0, OP_NOP,    COND_ALWAYS,   PC_FETCH);
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/sfs_if.sv -----
// Valid/ready channel interfaces for the fade sequencer request and response streams.
// Depends on sfs_pkg for field widths.
`timescale 1ns / 1ps

interface sfs_req_if;
	import sfs_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [LEN_W-1:0]  delta_ticks;
	logic [LEN_W-1:0]  fade_out_ticks;
	logic [LEN_W-1:0]  fade_in_ticks;

	modport source (output valid, action, delta_ticks, fade_out_ticks, fade_in_ticks,
		input ready);
	modport sink (input valid, action, delta_ticks, fade_out_ticks, fade_in_ticks,
		output ready);
endinterface

interface sfs_rsp_if;
	import sfs_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [PHASE_W-1:0] phase_now;
	logic               midpoint;
	logic [OPAC_W-1:0]  opacity;

	modport source (output valid, accepted, phase_now, midpoint, opacity, input ready);
	modport sink (input valid, accepted, phase_now, midpoint, opacity, output ready);
endinterface

// ----- rtl/core/sfs_ucode_rom.sv -----
// Read-only store of the sequencer microprogram, one control word per step.
// Depends on sfs_pkg for the table and the control word type.
`timescale 1ns / 1ps

module sfs_ucode_rom (
	input  logic [sfs_pkg::PC_W-1:0] pc,
	output sfs_pkg::sfs_cw_t         cw
);
	import sfs_pkg::*;

	assign cw = ucode(pc);

endmodule

// ----- rtl/core/sfs_sequencer.sv -----
// Step counter and branch unit that walks the microprogram.
// Depends on sfs_pkg and sfs_ucode_rom.
`timescale 1ns / 1ps

module sfs_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  sfs_pkg::sfs_flags_t flags,
	output sfs_pkg::sfs_cw_t    cw
);
	import sfs_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            take_branch;

	sfs_ucode_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	always_comb begin
		case (cw.cond)
			COND_NEVER:    take_branch = 1'b0;
			COND_ALWAYS:   take_branch = 1'b1;
			COND_NO_INPUT: take_branch = !flags.in_valid;
			COND_SKIP_DIV: take_branch = flags.skip_div;
			COND_DIV_MORE: take_branch = flags.div_more;
			COND_OUT_BUSY: take_branch = flags.out_busy;
			default:       take_branch = 1'b1;
		endcase
		pc_d = take_branch ? cw.target : pc_q + PC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- rtl/core/sfs_datapath.sv -----
// Fade state registers, bit-serial progress divider, opacity multiplier and result register.
// Depends on sfs_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "smoothstep_fade_sequencer_core_macros.svh"

module sfs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sfs_pkg::sfs_cw_t    cw,
	output sfs_pkg::sfs_flags_t flags,
	sfs_req_if.sink             req,
	sfs_rsp_if.source           rsp
);
	import sfs_pkg::*;

	localparam logic [LEN_W:0]   ONE_Q16   = 17'h10000;
	localparam logic [W_W-1:0]   THREE_Q16 = 18'd196608;
	localparam logic [TIME_BITS-1:0] EL_MAX = {TIME_BITS{1'b1}};

	// Fade state.
	logic [PHASE_W-1:0]   phase_q, phase_d;
	logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
	logic [LEN_W-1:0]     out_len_q, out_len_d;
	logic [LEN_W-1:0]     in_len_q, in_len_d;
	logic                 acc_q, acc_d;
	logic                 mid_q, mid_d;
	logic                 accept;

	// Tick arithmetic.
	logic [SUM_W-1:0]     sum_w;
	logic [TIME_BITS-1:0] tick_el;

	// Progress.
	logic [LEN_W-1:0]     sel_len;
	logic                 full;
	logic                 full_q;
	logic [LEN_W-1:0]     r_q;
	logic [LEN_W-1:0]     q_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LEN_W:0]       r2;
	logic [LEN_W:0]       r_diff;
	logic                 r_ge;

	// Opacity.
	logic [LEN_W:0]       a17;
	logic [LEN_W:0]       v17;
	logic [LEN_W-1:0]     v_q;
	logic                 vfull_q;
	logic [2*LEN_W-1:0]   vv_q;
	logic [W_W-1:0]       w_q;
	logic [PP_W-1:0]      ph_q;
	logic [PP_W-1:0]      pl_q;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-33:0]   scaled;
	logic [OPAC_W-1:0]    opac_q;

	// Result register.
	logic                 out_valid_q;
	logic                 out_busy;
	logic                 out_load;
	logic                 o_acc_q;
	logic [PHASE_W-1:0]   o_phase_q;
	logic                 o_mid_q;
	logic [OPAC_W-1:0]    o_opac_q;

	assign req.ready = cw.take_in;
	assign accept    = req.valid && req.ready;

	assign sum_w   = SUM_W'(elapsed_q) + SUM_W'(req.delta_ticks);
	assign tick_el = (sum_w > SUM_W'(EL_MAX)) ? EL_MAX : sum_w[TIME_BITS-1:0];

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		out_len_d = out_len_q;
		in_len_d  = in_len_q;
		acc_d     = 1'b0;
		mid_d     = 1'b0;
		case (req.action)
			ACT_START: begin
				if (phase_q == PH_IDLE) begin
					out_len_d = (req.fade_out_ticks == '0) ? LEN_W'(1) : req.fade_out_ticks;
					in_len_d  = (req.fade_in_ticks == '0) ? LEN_W'(1) : req.fade_in_ticks;
					elapsed_d = '0;
					phase_d   = PH_OUT;
					acc_d     = 1'b1;
				end
			end
			ACT_CANCEL: begin
				phase_d   = PH_IDLE;
				elapsed_d = '0;
			end
			ACT_TICK: begin
				if (phase_q != PH_IDLE) begin
					elapsed_d = tick_el;
					if (phase_q == PH_OUT) begin
						if (CMP_W'(tick_el) >= CMP_W'(out_len_q)) begin
							phase_d   = PH_IN;
							elapsed_d = '0;
							mid_d     = 1'b1;
						end
					end else if (CMP_W'(tick_el) >= CMP_W'(in_len_q)) begin
						phase_d   = PH_IDLE;
						elapsed_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			out_len_q <= LEN_W'(1);
			in_len_q  <= LEN_W'(1);
		end else if (cw.op == OP_UPDATE && accept) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			out_len_q <= out_len_d;
			in_len_q  <= in_len_d;
		end
	end

	// Progress = elapsed * 2^16 / length, one quotient bit per step.
	assign sel_len = (phase_q == PH_IN) ? in_len_q : out_len_q;
	assign full    = CMP_W'(elapsed_q) >= CMP_W'(sel_len);
	assign r2      = {r_q, 1'b0};
	assign r_diff  = r2 - (LEN_W + 1)'(sel_len);
	assign r_ge    = r2 >= (LEN_W + 1)'(sel_len);

	assign a17 = full_q ? ONE_Q16 : (LEN_W + 1)'(q_q);

	always_comb begin
		case (phase_q)
			PH_OUT:  v17 = a17;
			PH_IN:   v17 = ONE_Q16 - a17;
			default: v17 = '0;
		endcase
	end

	assign prod   = PROD_W'({ph_q, {LEN_W{1'b0}}}) + PROD_W'(pl_q);
	assign scaled = prod[PROD_W-1:32];

	assign out_busy = out_valid_q && !rsp.ready;
	assign out_load = (cw.op == OP_OUT) && !out_busy;

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_UPDATE: begin
				if (accept) begin
					acc_q <= acc_d;
					mid_q <= mid_d;
				end
			end
			OP_PREP: begin
				r_q    <= LEN_W'(elapsed_q);
				q_q    <= '0;
				cnt_q  <= '0;
				full_q <= full;
			end
			OP_DIV: begin
				r_q   <= r_ge ? r_diff[LEN_W-1:0] : r2[LEN_W-1:0];
				q_q   <= {q_q[LEN_W-2:0], r_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_CVAL: begin
				v_q     <= v17[LEN_W-1:0];
				vfull_q <= v17[LEN_W];
			end
			OP_SQR: begin
				vv_q <= (2 * LEN_W)'(v_q) * (2 * LEN_W)'(v_q);
				w_q  <= THREE_Q16 - W_W'({v_q, 1'b0});
			end
			OP_MULH: ph_q <= PP_W'(vv_q[2*LEN_W-1:LEN_W]) * PP_W'(w_q);
			OP_MULL: pl_q <= PP_W'(vv_q[LEN_W-1:0]) * PP_W'(w_q);
			OP_FIN: begin
				if (vfull_q || (scaled > (PROD_W - 32)'(16'hFFFF))) begin
					opac_q <= '1;
				end else begin
					opac_q <= scaled[OPAC_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_acc_q   <= acc_q;
			o_phase_q <= phase_q;
			o_mid_q   <= mid_q;
			o_opac_q  <= opac_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.accepted  = o_acc_q;
	assign rsp.phase_now = o_phase_q;
	assign rsp.midpoint  = o_mid_q;
	assign rsp.opacity   = o_opac_q;

	assign flags.in_valid = req.valid;
	assign flags.skip_div = (phase_q == PH_IDLE) || full;
	assign flags.div_more = cnt_q != CNT_W'(DIV_STEPS - 1);
	assign flags.out_busy = out_busy;

	`SFS_ASSERT_NOW(a_idle_clears_time, phase_q == PH_IDLE, elapsed_q == '0,
		"elapsed time not cleared while idle")
	`SFS_ASSERT_NOW(a_div_remainder, cw.op == OP_DIV, r_q < sel_len,
		"divider remainder not below the fade length")
	`SFS_ASSERT_NOW(a_mid_enters_fade_in, out_load && mid_q, phase_q == PH_IN,
		"midpoint reported without entering fade-in")
	`SFS_ASSERT_NOW(a_start_enters_fade_out, out_load && acc_q, phase_q == PH_OUT,
		"start taken without entering fade-out")
	`SFS_ASSERT_NEXT(a_load_shows_result, out_load, out_valid_q,
		"result register loaded but not presented")

endmodule

// ----- rtl/core/smoothstep_fade_sequencer_core.sv -----
// Smoothstep fade sequencer core: idle, fade-out and fade-in phases with smoothstep opacity.
// Requests are taken one at a time: the next is accepted only after the previous result
// has been loaded into the result register. The 16-step bit-serial progress divider in
// the datapath is skipped when the phase is idle or the fade is done.
// Reset (arst_n low, asynchronous): idle phase, zero elapsed time, both lengths one, no result.
`timescale 1ns / 1ps

module smoothstep_fade_sequencer_core (
	input  logic      clk,
	input  logic      arst_n,
	sfs_req_if.sink   req,
	sfs_rsp_if.source rsp
);
	import sfs_pkg::*;

	// The sequencer walks a ten-step microprogram. Step zero waits for a request
	// transfer and applies the phase update (start, cancel or tick with a saturating
	// add of the delta). Step one prepares the progress division; when the phase is
	// idle or the elapsed time has reached the fade length, it branches past the
	// divider, since the progress is then known without dividing.
	sfs_cw_t    cw;
	sfs_flags_t flags;

	sfs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	// The datapath shares one restoring divider step for the progress, then forms
	// the cover value, squares it and scales it by 3 - 2v in two 16 by 18 bit
	// partial products before the saturating final sum. The result register lets
	// the next request transfer while a finished result still waits on the sink.
	sfs_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cw     (cw),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- tb/sv/fade_sequence_checker.sv -----
// Checker for the smoothstep fade sequencer: predicts each response and compares it.
// Depends on sfs_pkg and the request and response interfaces in sfs_if.
`timescale 1ns / 1ps

module fade_sequence_checker (
	input  logic        clk,
	input  logic        arst_n,
	sfs_req_if          req,
	sfs_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned open_results
);
	import sfs_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;
	localparam longint unsigned Q16_ONE = 64'd65536;

	typedef struct packed {
		logic               accepted;
		logic [PHASE_W-1:0] phase_now;
		logic               midpoint;
		logic [OPAC_W-1:0]  opacity;
	} fade_result_t;

	// Shadow state of the sequencer.
	logic [PHASE_W-1:0]   fade_phase;
	logic [TIME_BITS-1:0] elapsed;
	logic [LEN_W-1:0]     out_len;
	logic [LEN_W-1:0]     in_len;

	fade_result_t expected_q[$];
	fade_result_t want;
	int unsigned  result_index;

	// Smoothstep cover level 3v^2 - 2v^3 of the clamped progress, in Q0.16.
	function automatic logic [OPAC_W-1:0] cover_opacity();
		longint unsigned len;
		longint unsigned prog;
		longint unsigned v;
		longint unsigned s;
		if (fade_phase == PH_IDLE)
			return '0;
		len = (fade_phase == PH_OUT) ? out_len : in_len;
		if (elapsed >= len)
			prog = Q16_ONE;
		else
			prog = (longint'(elapsed) * Q16_ONE) / len;
		v = (fade_phase == PH_OUT) ? prog : Q16_ONE - prog;
		s = (v * v * (3 * Q16_ONE - 2 * v)) >> 32;
		return (s > 65535) ? '1 : s[OPAC_W-1:0];
	endfunction

	// Applies one request to the shadow state and returns the response it must produce.
	function automatic fade_result_t advance_fade(input logic [ACT_W-1:0] action,
		input logic [LEN_W-1:0] delta, input logic [LEN_W-1:0] fade_out,
		input logic [LEN_W-1:0] fade_in);
		fade_result_t r;
		logic [TIME_BITS:0] sum;
		r = '0;
		case (action)
			ACT_START: begin
				if (fade_phase == PH_IDLE) begin
					out_len    = (fade_out == '0) ? LEN_W'(1) : fade_out;
					in_len     = (fade_in == '0) ? LEN_W'(1) : fade_in;
					elapsed    = '0;
					fade_phase = PH_OUT;
					r.accepted = 1'b1;
				end
			end
			ACT_CANCEL: begin
				fade_phase = PH_IDLE;
				elapsed    = '0;
			end
			ACT_TICK: begin
				if (fade_phase != PH_IDLE) begin
					sum     = {1'b0, elapsed} + (TIME_BITS + 1)'(delta);
					elapsed = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
					if (fade_phase == PH_OUT) begin
						if (elapsed >= out_len) begin
							fade_phase = PH_IN;
							elapsed    = '0;
							r.midpoint = 1'b1;
						end
					end else if (elapsed >= in_len) begin
						fade_phase = PH_IDLE;
						elapsed    = '0;
					end
				end
			end
			default: begin
			end
		endcase
		r.phase_now = fade_phase;
		r.opacity   = cover_opacity();
		return r;
	endfunction

	task automatic note_mismatch(input string why, input fade_result_t exp_r,
		input fade_result_t got_r);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: response %0d %s: accepted %0b/%0b phase %0d/%0d midpoint %0b/%0b opacity %0d/%0d (expected/actual)",
				$realtime, result_index, why, exp_r.accepted, got_r.accepted,
				exp_r.phase_now, got_r.phase_now, exp_r.midpoint, got_r.midpoint,
				exp_r.opacity, got_r.opacity);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_phase   = PH_IDLE;
			elapsed      = '0;
			out_len      = LEN_W'(1);
			in_len       = LEN_W'(1);
			expected_q.delete();
			open_results = 0;
			result_index = 0;
		end else begin
			if (req.valid && req.ready)
				expected_q.push_back(advance_fade(req.action, req.delta_ticks,
					req.fade_out_ticks, req.fade_in_ticks));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					note_mismatch("without request", '0,
						{rsp.accepted, rsp.phase_now, rsp.midpoint, rsp.opacity});
				end else begin
					want = expected_q.pop_front();
					if (rsp.accepted !== want.accepted || rsp.phase_now !== want.phase_now ||
						rsp.midpoint !== want.midpoint || rsp.opacity !== want.opacity)
						note_mismatch("mismatch", want,
							{rsp.accepted, rsp.phase_now, rsp.midpoint, rsp.opacity});
				end
				result_index++;
			end
			open_results = expected_q.size();
		end
	end

endmodule

// ----- tb/sv/smoothstep_fade_sequencer_core_tb.sv -----
// Top of the fade sequencer testbench: clock, reset, request stimulus and response back-pressure.
// Depends on sfs_pkg, sfs_if, the core and fade_sequence_checker.
`timescale 1ns / 1ps

module smoothstep_fade_sequencer_core_tb;
	import sfs_pkg::*;

	// The core ignores the fourth action code; it has no name in the package.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Stimulus size, idle gaps and time limits. The slowest item costs roughly a sender
	// gap, a full divider pass and a receiver stall, so the limit below leaves several
	// times the worst case for the whole run.
	localparam int unsigned ITEM_GOAL   = 1500;
	localparam int unsigned MAX_GAP     = 11;
	localparam int unsigned CALM_EVERY  = 64;
	localparam int unsigned LONG_STALL  = 600;
	localparam int unsigned STALL_AFTER = 200;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 800000;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned open_results;
	int unsigned sent_items;
	int unsigned taken_results;
	logic        send_calm;
	logic        take_calm;

	sfs_req_if req_ch ();
	sfs_rsp_if rsp_ch ();

	smoothstep_fade_sequencer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fade_sequence_checker seq_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.mismatches   (mismatches),
		.open_results (open_results)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [LEN_W-1:0] rnd16();
		return LEN_W'($urandom_range(0, 65535));
	endfunction

	// Fade lengths: mostly short or moderate so that fades finish in a few ticks, with some
	// full-range lengths. Zero is included and is taken by the core as one.
	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return LEN_W'($urandom_range(0, 8));
		if (r < 8)
			return LEN_W'($urandom_range(0, 2000));
		return rnd16();
	endfunction

	// Offers one request and returns once its transfer has happened. Before the request the
	// sender idles for a random number of cycles, except in calm stretches where it offers
	// back to back. When there is no gap, valid simply stays high and only the payload moves.
	task automatic send_req(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] delta,
		input logic [LEN_W-1:0] fade_out, input logic [LEN_W-1:0] fade_in);
		int unsigned gap;
		if (sent_items % CALM_EVERY == 0)
			send_calm = ($urandom_range(0, 3) == 0);
		gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.delta_ticks    <= delta;
		req_ch.fade_out_ticks <= fade_out;
		req_ch.fade_in_ticks  <= fade_in;
		do @(posedge clk); while (!req_ch.ready);
		sent_items++;
	endtask

	// Directed part. It walks the corners: ticks, cancels and the unused code while idle,
	// zero lengths raised to one, a start refused while a fade runs, a tick of zero, the
	// midpoint step with its full opacity, the largest lengths, a tick that overshoots the
	// length, an elapsed time that saturates at its maximum and cancels in both fade phases.
	task automatic run_directed();
		send_req(ACT_TICK,   16'hFFFF, rnd16(), rnd16());
		send_req(ACT_CANCEL, rnd16(), rnd16(), rnd16());
		send_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_req(ACT_START,  rnd16(), 16'h0000, 16'h0000);
		send_req(ACT_START,  rnd16(), 16'hFFFF, 16'hFFFF);
		send_req(ACT_TICK,   16'h0000, rnd16(), rnd16());
		send_req(ACT_TICK,   16'h0001, rnd16(), rnd16());
		send_req(ACT_TICK,   16'h0000, rnd16(), rnd16());
		send_req(ACT_TICK,   16'h0001, rnd16(), rnd16());
		send_req(ACT_START,  16'h0000, 16'hFFFF, 16'hFFFF);
		send_req(ACT_TICK,   16'h7FFF, rnd16(), rnd16());
		send_req(ACT_TICK,   16'hFFFF, rnd16(), rnd16());
		send_req(ACT_TICK,   16'h8000, rnd16(), rnd16());
		send_req(ACT_UNUSED, rnd16(), rnd16(), rnd16());
		send_req(ACT_START,  rnd16(), 16'h0002, 16'h0002);
		send_req(ACT_TICK,   16'hFFFF, rnd16(), rnd16());
		send_req(ACT_START,  rnd16(), 16'h0003, 16'hFFFF);
		send_req(ACT_TICK,   16'h0001, rnd16(), rnd16());
		send_req(ACT_CANCEL, rnd16(), rnd16(), rnd16());
		send_req(ACT_START,  rnd16(), 16'h5555, 16'hAAAA);
		send_req(ACT_TICK,   16'hAAAA, rnd16(), rnd16());
		send_req(ACT_TICK,   16'h5555, rnd16(), rnd16());
		send_req(ACT_CANCEL, rnd16(), rnd16(), rnd16());
		send_req(ACT_START,  rnd16(), 16'h1234, 16'h0001);
	endtask

	// One well-formed fade: a start, then ticks that walk through fade-out and fade-in in a
	// random number of steps. The running sum mirrors how far the fade should have come, so
	// nearly every tick lands in an active phase. Now and then a cancel cuts the fade short,
	// a refused start or the unused code is slipped in, or a tick of any size overshoots.
	task automatic run_fade_sequence();
		logic [LEN_W-1:0] lens [2];
		logic [LEN_W-1:0] delta;
		int unsigned      target;
		int unsigned      total;
		int unsigned      span;
		int unsigned      steps;
		int unsigned      pick;
		lens[0] = pick_length();
		lens[1] = pick_length();
		send_req(ACT_START, rnd16(), lens[0], lens[1]);
		for (int p = 0; p < 2; p++) begin
			target = (lens[p] == '0) ? 1 : lens[p];
			steps  = $urandom_range(1, 10);
			total  = 0;
			while (total < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					send_req(ACT_CANCEL, rnd16(), rnd16(), rnd16());
					return;
				end
				if (pick < 4)
					send_req(ACT_START, rnd16(), rnd16(), rnd16());
				else if (pick < 5)
					send_req(ACT_UNUSED, rnd16(), rnd16(), rnd16());
				span = (pick >= 96) ? 65535 : 2 * target / steps + 1;
				if (span > 65535)
					span = 65535;
				delta = LEN_W'($urandom_range(0, span));
				send_req(ACT_TICK, delta, rnd16(), rnd16());
				total = (total + delta > 65535) ? 65535 : total + delta;
			end
		end
		// Between fades, occasionally poke the idle core.
		pick = $urandom_range(0, 9);
		if (pick == 0)
			send_req(ACT_TICK, rnd16(), rnd16(), rnd16());
		else if (pick == 1)
			send_req(ACT_CANCEL, rnd16(), rnd16(), rnd16());
		else if (pick == 2)
			send_req(ACT_UNUSED, rnd16(), rnd16(), rnd16());
	endtask

	// Stimulus and verdict. Reset is held at the start and never again.
	initial begin
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= ACT_TICK;
		req_ch.delta_ticks    <= '0;
		req_ch.fade_out_ticks <= '0;
		req_ch.fade_in_ticks  <= '0;
		sent_items = 0;
		send_calm  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (sent_items < ITEM_GOAL)
			run_fade_sequence();
		req_ch.valid <= 1'b0;
		// Let the checker see the last request transfer, then drain every expected response.
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		// Extra cycles so a stray response after the last expected one is still caught.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Response side. For each response the receiver holds ready low for a random number of
	// cycles, with calm stretches of no stall. Once, after a couple hundred transfers, it
	// holds off for a long stretch while the sender keeps offering, so the core fills up
	// and has to stall its request side.
	initial begin
		int unsigned hold;
		rsp_ch.ready <= 1'b0;
		taken_results = 0;
		take_calm     = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken_results % CALM_EVERY == 0)
				take_calm = ($urandom_range(0, 3) == 0);
			hold = take_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (taken_results == STALL_AFTER)
				hold = LONG_STALL;
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken_results++;
		end
	end

	// Watchdog: a hung handshake or a missing response ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sfs_pkg.sv
rtl/core/sfs_if.sv
rtl/core/sfs_ucode_rom.sv
rtl/core/sfs_sequencer.sv
rtl/core/sfs_datapath.sv
rtl/core/smoothstep_fade_sequencer_core.sv
tb/sv/fade_sequence_checker.sv
tb/sv/smoothstep_fade_sequencer_core_tb.sv
